/* rtl/sat_pkg.sv */
`default_nettype none

package sat_pkg;

  // One request as it arrives on the command port.
  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  seg_a;
    logic [7:0]  seg_b;
    logic [47:0] current_world;
    logic [47:0] parent_world;
  } request_t;

  // One result as it leaves on the strobed result port.
  typedef struct packed {
    logic        reaches;
    logic [47:0] world;
    logic [47:0] new_counter;
    logic [1:0]  status;
  } result_t;

  // Operation codes.
  localparam logic [2:0] OP_QUERY      = 3'd0;
  localparam logic [2:0] OP_NEW        = 3'd1;
  localparam logic [2:0] OP_ADVANCE    = 3'd2;
  localparam logic [2:0] OP_GRAFT      = 3'd3;
  localparam logic [2:0] OP_ADD_PARENT = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_FULL        = 2'd1;
  localparam logic [1:0] ST_NOT_EARLIER = 2'd2;

  // Width of one word of an ancestor row.
  localparam int unsigned WORD_BITS = 64;

  // What the datapath decided a request needs, once its fields are registered.
  typedef enum logic [2:0] {
    PLAN_DONE,
    PLAN_QUERY,
    PLAN_NEW,
    PLAN_ADVANCE,
    PLAN_GRAFT,
    PLAN_ADD
  } plan_t;

  // Datapath action for the current cycle.
  typedef enum logic [3:0] {
    ACT_IDLE,
    ACT_CAPTURE,
    ACT_RD_QUERY,
    ACT_RD_PARENT,
    ACT_RD_NEWEST,
    ACT_WR_ZERO,
    ACT_WR_NEW,
    ACT_WR_SIDE,
    ACT_WR_ADD
  } act_t;

  typedef struct packed {
    act_t act;
    logic word_next;
    logic finish;
  } cmd_t;

  typedef struct packed {
    plan_t plan;
    logic  last_word;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/sat_ram.sv */
`default_nettype none

module sat_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/sat_ctrl.sv */
`default_nettype none

module sat_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sat_pkg::stat_t stat,
  output sat_pkg::cmd_t  cmd
);

  import sat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_QREAD,
    S_ZERO,
    S_PRD,
    S_PWR,
    S_PSIDE,
    S_ARDN,
    S_AWR,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_DECIDE;
            busy  <= 1'b1;
          end
        end
        S_DECIDE: begin
          unique case (stat.plan)
            PLAN_DONE:  state <= S_FINISH;
            PLAN_QUERY: state <= S_QREAD;
            PLAN_NEW:   state <= S_ZERO;
            default:    state <= S_PRD;
          endcase
        end
        S_QREAD: state <= S_FINISH;
        S_ZERO: begin
          if (stat.last_word) begin
            state <= S_FINISH;
          end
        end
        S_PRD: begin
          if (stat.plan == PLAN_ADD) begin
            state <= S_ARDN;
          end else begin
            state <= S_PWR;
          end
        end
        S_PWR: begin
          if (stat.plan == PLAN_GRAFT) begin
            state <= S_PSIDE;
          end else if (stat.last_word) begin
            state <= S_FINISH;
          end else begin
            state <= S_PRD;
          end
        end
        S_PSIDE, S_AWR: begin
          if (stat.last_word) begin
            state <= S_FINISH;
          end else begin
            state <= S_PRD;
          end
        end
        S_ARDN: state <= S_AWR;
        S_FINISH: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.act       = ACT_IDLE;
    cmd.word_next = 1'b0;
    cmd.finish    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.act = ACT_CAPTURE;
        end
      end
      S_QREAD: cmd.act = ACT_RD_QUERY;
      S_ZERO: begin
        cmd.act       = ACT_WR_ZERO;
        cmd.word_next = 1'b1;
      end
      S_PRD: cmd.act = ACT_RD_PARENT;
      S_PWR: begin
        cmd.act       = ACT_WR_NEW;
        cmd.word_next = (stat.plan != PLAN_GRAFT);
      end
      S_PSIDE: begin
        cmd.act       = ACT_WR_SIDE;
        cmd.word_next = 1'b1;
      end
      S_ARDN: cmd.act = ACT_RD_NEWEST;
      S_AWR: begin
        cmd.act       = ACT_WR_ADD;
        cmd.word_next = 1'b1;
      end
      S_FINISH: cmd.finish = 1'b1;
      default: cmd.act = ACT_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/sat_datapath.sv */
`default_nettype none

module sat_datapath #(
  parameter int MAX_SEGMENTS = 256,
  parameter int INDEX_BITS   = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  sat_pkg::request_t request,
  input  sat_pkg::cmd_t     cmd,
  output sat_pkg::stat_t    stat,
  output sat_pkg::result_t  result,
  output logic              done
);

  import sat_pkg::*;

  localparam int ROW_WORDS = (MAX_SEGMENTS + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH     = MAX_SEGMENTS * ROW_WORDS;
  localparam int AW        = $clog2(DEPTH);
  localparam int IW        = $clog2(MAX_SEGMENTS);
  localparam int CW        = $clog2(MAX_SEGMENTS + 1);
  localparam int WCW       = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam logic [CW:0]    LIMIT     = (CW + 1)'(MAX_SEGMENTS);
  localparam logic [WCW-1:0] LAST_WORD = WCW'(ROW_WORDS - 1);

  request_t         req;
  logic [CW-1:0]    count;
  logic [WCW-1:0]   wcnt;
  logic [63:0]      hold;
  result_t          result_next;

  logic [47:0]      src_world;
  logic [47:0]      ps48;
  logic [IW-1:0]    ps_id;
  logic [CW:0]      count_x;
  logic             ps_below_count;
  logic             ps_below_newest;
  logic             room_one;
  logic             room_two;
  logic             sb_present;
  logic [63:0]      fw_id;
  logic [63:0]      fw_side;
  logic             fast_reaches;
  logic [1:0]       status_code;
  plan_t            plan;

  logic [IW-1:0]    row_new;
  logic [IW-1:0]    row_side;
  logic [IW-1:0]    row_newest;
  logic [IW-1:0]    row_query;
  logic [IW-1:0]    row_sel;
  logic [WCW-1:0]   word_sel;
  logic [AW-1:0]    addr;
  logic             we;
  logic             re;
  logic [63:0]      wdata;
  logic [63:0]      rdata;
  logic [63:0]      parent_word;
  logic [63:0]      merged;
  logic [63:0]      bit_ps;
  logic [63:0]      bit_id;

  // One-hot mask of a segment's bit inside word w of a row.
  function automatic logic [63:0] row_bit(input logic [IW-1:0] id, input logic [WCW-1:0] w);
    logic [15:0] id_x;
    logic [63:0] bits;
    id_x = 16'(id);
    bits = '0;
    if (id_x[15:6] == 10'(w)) begin
      bits[id_x[5:0]] = 1'b1;
    end
    return bits;
  endfunction

  assign src_world       = (req.operation == OP_ADD_PARENT) ? req.parent_world
                                                            : req.current_world;
  assign ps48            = src_world >> INDEX_BITS;
  assign ps_id           = ps48[IW-1:0];
  assign count_x         = {1'b0, count};
  assign ps_below_count  = ps48 < 48'(count);
  assign ps_below_newest = ps48 < (48'(count) - 48'd1);
  assign room_one        = count_x < LIMIT;
  assign room_two        = (count_x + (CW + 1)'(1)) < LIMIT;
  assign sb_present      = (req.seg_b != 8'd0) && (16'(req.seg_b) < 16'(count));
  assign fw_id           = 64'(count) << INDEX_BITS;
  assign fw_side         = (64'(count) + 64'd1) << INDEX_BITS;

  always_comb begin
    plan         = PLAN_DONE;
    fast_reaches = 1'b0;
    status_code  = ST_OK;
    unique case (req.operation)
      OP_QUERY: begin
        if (req.seg_a == req.seg_b) begin
          fast_reaches = 1'b1;
        end else if (!sb_present) begin
          fast_reaches = req.seg_a < req.seg_b;
        end else if (req.seg_a < req.seg_b) begin
          plan = PLAN_QUERY;
        end
      end
      OP_NEW: begin
        if (!room_one) begin
          status_code = ST_FULL;
        end else begin
          plan = PLAN_NEW;
        end
      end
      OP_ADVANCE: begin
        if (!room_one) begin
          status_code = ST_FULL;
        end else if (!ps_below_count) begin
          status_code = ST_NOT_EARLIER;
        end else begin
          plan = PLAN_ADVANCE;
        end
      end
      OP_GRAFT: begin
        if (!room_two) begin
          status_code = ST_FULL;
        end else if (!ps_below_count) begin
          status_code = ST_NOT_EARLIER;
        end else begin
          plan = PLAN_GRAFT;
        end
      end
      OP_ADD_PARENT: begin
        if (!ps_below_newest) begin
          status_code = ST_NOT_EARLIER;
        end else begin
          plan = PLAN_ADD;
        end
      end
      default: plan = PLAN_DONE;
    endcase
  end

  assign stat.plan      = plan;
  assign stat.last_word = (wcnt == LAST_WORD);

  always_comb begin
    result_next.reaches     = (plan == PLAN_QUERY) ? rdata[req.seg_a[5:0]] : fast_reaches;
    result_next.world       = '0;
    result_next.new_counter = req.current_world;
    result_next.status      = status_code;
    if (plan == PLAN_NEW || plan == PLAN_ADVANCE || plan == PLAN_GRAFT) begin
      result_next.world = fw_id[47:0];
    end
    if (plan == PLAN_ADVANCE) begin
      result_next.new_counter = fw_id[47:0];
    end else if (plan == PLAN_GRAFT) begin
      result_next.new_counter = fw_side[47:0];
    end
  end

  // Row addressing and the merge of a parent word into a child word.
  assign row_new     = IW'(count);
  assign row_side    = IW'(count + CW'(1));
  assign row_newest  = IW'(count - CW'(1));
  assign row_query   = IW'(req.seg_b);
  assign bit_ps      = row_bit(ps_id, wcnt);
  assign bit_id      = row_bit(row_new, wcnt);
  assign parent_word = (ps_id != '0) ? rdata : '0;
  assign merged      = parent_word | bit_ps;

  always_comb begin
    row_sel  = row_new;
    word_sel = wcnt;
    we       = 1'b0;
    re       = 1'b0;
    wdata    = '0;
    unique case (cmd.act)
      ACT_RD_QUERY: begin
        row_sel  = row_query;
        word_sel = WCW'(req.seg_a >> 6);
        re       = 1'b1;
      end
      ACT_RD_PARENT: begin
        row_sel = ps_id;
        re      = 1'b1;
      end
      ACT_RD_NEWEST: begin
        row_sel = row_newest;
        re      = 1'b1;
      end
      ACT_WR_ZERO: begin
        we = 1'b1;
      end
      ACT_WR_NEW: begin
        we    = 1'b1;
        wdata = merged;
      end
      ACT_WR_SIDE: begin
        row_sel = row_side;
        we      = 1'b1;
        wdata   = hold | bit_id;
      end
      ACT_WR_ADD: begin
        row_sel = row_newest;
        we      = 1'b1;
        wdata   = rdata | hold | bit_ps;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign addr = AW'(row_sel) * AW'(ROW_WORDS) + AW'(word_sel);

  sat_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_rows (
    .clk   (clk),
    .we    (we),
    .re    (re),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(1);
      wcnt  <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.act == ACT_CAPTURE) begin
        wcnt <= '0;
      end else if (cmd.word_next) begin
        wcnt <= wcnt + WCW'(1);
      end
      if (cmd.finish) begin
        if (plan == PLAN_NEW || plan == PLAN_ADVANCE) begin
          count <= count + CW'(1);
        end else if (plan == PLAN_GRAFT) begin
          count <= count + CW'(2);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act == ACT_CAPTURE) begin
      req <= request;
    end
    if (cmd.act == ACT_RD_NEWEST) begin
      hold <= parent_word;
    end else if (cmd.act == ACT_WR_NEW) begin
      hold <= merged;
    end
    if (cmd.finish) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/segment_ancestry_table_top.sv */
// Channel   Direction  Handshake                       Payload
// request   in         start high while busy is low    request (sat_pkg::request_t)
// result    out        done high for one cycle         result  (sat_pkg::result_t)
//
// Every accepted request gives exactly one result. With W = (MAX_SEGMENTS + 63) / 64
// row words, busy holds until the result is registered, and done strobes as busy falls.
// A query from the ids alone or a request with an error status touches no row; a row
// query reads one word; a new segment writes W words; an advance also reads each parent
// word; a graft or an added parent adds a third access per word, all through the single
// row memory port. Reset is synchronous; no clearing pass follows it. The receiver
// cannot stall, and a new request may be taken in the same cycle that done is high.
`default_nettype none

module segment_ancestry_table_top #(
  parameter int MAX_SEGMENTS = 256,
  parameter int INDEX_BITS   = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sat_pkg::request_t request,
  output logic              done,
  output sat_pkg::result_t  result
);

  import sat_pkg::*;

  // The controller walks each request through its memory steps; the datapath owns
  // the segment count, the row memory and the result register. They talk only
  // through the command and status structs below.
  cmd_t  cmd;
  stat_t stat;

  // Segments are appended in id order, so a segment is present exactly when its id
  // lies between one and the segment count. A row's contents are only ever used while its
  // segment is present, and every row is fully written when its segment opens, so
  // the row memory needs no clearing after reset.
  sat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Each row is stored as W words of 64 bits. A query reads one word of the
  // descendant's row. Creating a segment by advance or graft reads the parent row
  // one word at a time and writes the merged word into the new row; a graft writes
  // the side segment's word right after it. An added parent reads the parent word,
  // then the newest segment's word, and writes back their union with the parent's own bit.
  sat_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .INDEX_BITS   (INDEX_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

endmodule

`default_nettype wire
